### rtl/core/l4hp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4hp_pkg
// Types, codes and constants shared by the L4 header parser.
// ----------------------------------------------------------------------------
package l4hp_pkg;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_V4    = 3'd1;
  localparam logic [2:0] PH_V6    = 3'd2;
  localparam logic [2:0] PH_EXT   = 3'd3;
  localparam logic [2:0] PH_L4    = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_ERROR = 3'd6;

  localparam logic [7:0] PR_HOP   = 8'd0;
  localparam logic [7:0] PR_ICMP  = 8'd1;
  localparam logic [7:0] PR_TCP   = 8'd6;
  localparam logic [7:0] PR_UDP   = 8'd17;
  localparam logic [7:0] PR_ROUTE = 8'd43;
  localparam logic [7:0] PR_FRAG  = 8'd44;
  localparam logic [7:0] PR_ICMP6 = 8'd58;
  localparam logic [7:0] PR_DEST  = 8'd60;
  localparam logic [7:0] PR_SCTP  = 8'd132;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_UNSUPP   = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [3:0]  ip_type;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [3:0]  tcp_flags;
    logic [15:0] payload_size;
  } out_item_t;

  // parse context handed from the byte walker to the result formatter
  typedef struct packed {
    logic [2:0]   phase;
    logic [2:0]   error_code;
    logic [7:0]   next_protocol;
    logic [15:0]  ip_header_length;
    logic [15:0]  captured_length;
    logic [127:0] src_addr;
    logic [127:0] dst_addr;
    logic [31:0]  port_pair;
    logic [63:0]  seq_ack;
    logic [3:0]   tcp_header_words;
    logic [3:0]   flag_bits;
  } parse_ctx_t;

endpackage

### rtl/core/l4hp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4hp_stream_if
// Valid/ready channel carrying one item of a generic payload type.
// ----------------------------------------------------------------------------
interface l4hp_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/l4hp_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4hp_walker
// Per-byte header walk: takes one registered byte, updates the parse state,
// and presents the context of the packet including this byte.
// ----------------------------------------------------------------------------
module l4hp_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  l4hp_pkg::in_item_t   item,
  output logic                 emit,
  output l4hp_pkg::parse_ctx_t ctx_nxt
);
  import l4hp_pkg::*;

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [11:0] ext_left_r, ext_left_nxt;
  logic [5:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  ext_next_r, ext_next_nxt;
  parse_ctx_t  ctx_r, c, ctx_q;

  function automatic logic is_ext(input logic [7:0] p);
    return p == PR_HOP || p == PR_DEST || p == PR_ROUTE || p == PR_FRAG;
  endfunction

  logic [7:0]  b;
  logic [15:0] o;
  logic        do_enter, allow_ext;
  logic [7:0]  enter_p;
  logic [5:0]  ihl4;
  logic [11:0] ext_dec;
  logic [16:0] o_plus1;

  assign b = item.data_byte;
  assign o = byte_offset_r;
  assign o_plus1 = {1'b0, o} + 17'd1;

  always_comb begin
    c               = ctx_r;
    byte_offset_nxt = byte_offset_r;
    ext_left_nxt    = ext_left_r;
    hdr_idx_nxt     = hdr_idx_r;
    ext_next_nxt    = ext_next_r;
    do_enter        = 1'b0;
    allow_ext       = 1'b0;
    enter_p         = 8'd0;
    ihl4            = {b[3:0], 2'b00};
    ext_dec         = 12'd0;
    emit            = 1'b0;
    if (step && (item.first_byte || ctx_r.phase != PH_IDLE)) begin
      emit = item.last_byte;
      if (item.first_byte) begin
        c = '0;
        byte_offset_nxt = '0;
        ext_left_nxt = '0;
        hdr_idx_nxt = '0;
        ext_next_nxt = '0;
        c.captured_length = item.packet_length;
        if (item.ip_type != 4'd4 && item.ip_type != 4'd6) begin
          c.phase = PH_ERROR;
          c.error_code = ST_BAD_TYPE;
        end else if (b[7:4] != item.ip_type) begin
          c.phase = PH_ERROR;
          c.error_code = ST_VERSION;
        end else if (item.ip_type == 4'd4) begin
          c.ip_header_length = (ihl4 < 6'd20) ? 16'd20 : {10'd0, ihl4};
          c.phase = PH_V4;
        end else begin
          c.phase = PH_V6;
        end
      end else begin
        case (ctx_r.phase)
          PH_V4: begin
            if (o == 16'd9) c.next_protocol = b;
            else if (o >= 16'd12 && o <= 16'd15)
              c.src_addr = {96'd0, ctx_r.src_addr[23:0], b};
            else if (o >= 16'd16 && o <= 16'd19)
              c.dst_addr = {96'd0, ctx_r.dst_addr[23:0], b};
            if (o_plus1 >= {1'b0, ctx_r.ip_header_length}) begin
              do_enter = 1'b1;
              enter_p = c.next_protocol;
            end
          end
          PH_V6: begin
            if (o == 16'd6) c.next_protocol = b;
            else if (o >= 16'd8 && o <= 16'd23)
              c.src_addr = {ctx_r.src_addr[119:0], b};
            else if (o >= 16'd24 && o <= 16'd39)
              c.dst_addr = {ctx_r.dst_addr[119:0], b};
            if (o == 16'd39) begin
              c.ip_header_length = 16'd40;
              do_enter = 1'b1;
              allow_ext = 1'b1;
              enter_p = c.next_protocol;
            end
          end
          PH_EXT: begin
            ext_dec = ext_left_r;
            if (hdr_idx_r == 6'd0) ext_next_nxt = b;
            else if (hdr_idx_r == 6'd1 && ctx_r.next_protocol != PR_FRAG)
              ext_dec = {1'b0, b, 3'b111};
            if (ext_dec != 12'd0) ext_dec = ext_dec - 12'd1;
            ext_left_nxt = ext_dec;
            if (hdr_idx_r < 6'd63) hdr_idx_nxt = hdr_idx_r + 6'd1;
            if (ext_dec == 12'd0) begin
              c.ip_header_length = o_plus1[16] ? 16'hFFFF : o_plus1[15:0];
              do_enter = 1'b1;
              allow_ext = 1'b1;
              enter_p = ext_next_nxt;
            end
          end
          PH_L4: begin
            if (hdr_idx_r <= 6'd3) c.port_pair = {ctx_r.port_pair[23:0], b};
            else if (hdr_idx_r <= 6'd11) c.seq_ack = {ctx_r.seq_ack[55:0], b};
            else if (hdr_idx_r == 6'd12) c.tcp_header_words = b[7:4];
            else if (hdr_idx_r == 6'd13) c.flag_bits = {b[4], b[2], b[0], b[1]};
            hdr_idx_nxt = hdr_idx_r + 6'd1;
            if (ctx_r.next_protocol == PR_TCP ? hdr_idx_r >= 6'd13 : hdr_idx_r >= 6'd3)
              c.phase = PH_DONE;
          end
          default: ;
        endcase
        if (do_enter) begin
          c.next_protocol = enter_p;
          hdr_idx_nxt = '0;
          if (allow_ext && is_ext(enter_p)) begin
            c.phase = PH_EXT;
            ext_left_nxt = 12'd8;
          end else if (enter_p == PR_TCP || enter_p == PR_UDP || enter_p == PR_SCTP) begin
            c.phase = PH_L4;
          end else if (enter_p == PR_ICMP || enter_p == PR_ICMP6) begin
            c.phase = PH_DONE;
          end else begin
            c.phase = PH_ERROR;
            c.error_code = ST_UNSUPP;
          end
        end
      end
      if (byte_offset_nxt != 16'hFFFF) byte_offset_nxt = byte_offset_nxt + 16'd1;
    end
  end

  assign ctx_nxt = c;

  // packet closes after its last byte
  always_comb begin
    ctx_q = c;
    if (emit) ctx_q.phase = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r         <= '0;
      byte_offset_r <= '0;
      ext_left_r    <= '0;
      hdr_idx_r     <= '0;
      ext_next_r    <= '0;
    end else begin
      ctx_r         <= ctx_q;
      byte_offset_r <= byte_offset_nxt;
      ext_left_r    <= ext_left_nxt;
      hdr_idx_r     <= hdr_idx_nxt;
      ext_next_r    <= ext_next_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.phase == PH_ERROR |-> ctx_r.error_code != ST_OK)
    else $error("error phase without error code");
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(emit) |-> ctx_r.phase == PH_IDLE)
    else $error("packet still open after last byte");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.phase == PH_V4 |-> ctx_r.ip_header_length >= 16'd20)
    else $error("IPv4 header length below minimum");
endmodule

### rtl/core/l4hp_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4hp_format
// Turns the final parse context into a result item.
// ----------------------------------------------------------------------------
module l4hp_format (
  input  l4hp_pkg::parse_ctx_t ctx,
  output l4hp_pkg::out_item_t  res
);
  import l4hp_pkg::*;

  logic [2:0]  st;
  logic [16:0] hdr;
  logic        l4;

  always_comb begin
    res = '0;
    if (ctx.phase == PH_ERROR) st = ctx.error_code;
    else if (ctx.phase == PH_DONE) st = ST_OK;
    else st = ST_TRUNC;
    hdr = {1'b0, ctx.ip_header_length} + {11'd0, ctx.tcp_header_words, 2'b00};
    l4 = ctx.next_protocol == PR_TCP || ctx.next_protocol == PR_UDP ||
         ctx.next_protocol == PR_SCTP;
    res.status = st;
    if (st == ST_OK || st == ST_UNSUPP) begin
      res.protocol      = ctx.next_protocol;
      res.src_addr_high = ctx.src_addr[127:64];
      res.src_addr_low  = ctx.src_addr[63:0];
      res.dst_addr_high = ctx.dst_addr[127:64];
      res.dst_addr_low  = ctx.dst_addr[63:0];
    end
    if (st == ST_OK && l4) begin
      res.src_port = ctx.port_pair[31:16];
      res.dst_port = ctx.port_pair[15:0];
    end
    if (st == ST_OK && ctx.next_protocol == PR_TCP) begin
      res.seq_number = ctx.seq_ack[63:32];
      res.ack_number = ctx.seq_ack[31:0];
      res.tcp_flags  = ctx.flag_bits;
      if ({1'b0, ctx.captured_length} > hdr)
        res.payload_size = ctx.captured_length - hdr[15:0];
    end
  end
endmodule

### rtl/core/ip_l4_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_l4_header_parser_core
// IPv4/IPv6 header parser with TCP/UDP/SCTP field extraction, one byte/cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_      in   packet byte, first/last marks, ip_type, packet_length
//  out_     out  status, protocol, addresses, ports, seq/ack, flags, payload
//
//  One byte per cycle unless the result register is stalled; input register, walk logic, result register.
//  The last byte passes through the input register; its result is then held in the result register.
//  Input register refills whenever it is empty or the result register can move on.
//  Synchronous active-low reset empties both registers and closes any packet.
// ----------------------------------------------------------------------------
module ip_l4_header_parser_core (
  input  logic          clk,
  input  logic          rst_n,
  l4hp_stream_if.sink   in_ch,
  l4hp_stream_if.source out_ch
);
  import l4hp_pkg::*;

  in_item_t   in_r;
  logic       in_vld_r;
  out_item_t  out_r;
  logic       out_vld_r;
  logic       emit, step, adv;
  parse_ctx_t ctx_nxt;
  out_item_t  res;

  assign adv   = !out_vld_r || out_ch.ready;
  assign step  = in_vld_r && adv;
  assign in_ch.ready = !in_vld_r || adv;

  l4hp_walker u_walk (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_r),
    .emit(emit), .ctx_nxt(ctx_nxt)
  );

  l4hp_format u_fmt (.ctx(ctx_nxt), .res(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (adv) out_vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_r <= in_ch.payload;
    if (emit) out_r <= res;
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> step)
    else $error("result without a byte step");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_r))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_r))
    else $error("held byte lost");
endmodule
